FILE: hw/rtl/rmvs_pkg.sv
package rmvs_pkg;

   // Fixed field widths
   localparam int SAMPLE_W = 16;
   localparam int SQUARE_W = 31;
   localparam int MEAN_W   = 16;
   localparam int VAR_W    = 31;
   localparam int SD_W     = 16;
   localparam int COUNT_W  = 7;

   // Run record queue between the front and back parts (depth is a power of two)
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              empty;
      logic [QCNT_W-1:0] level;
   } queue_status_type;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_DIVM  = 9'b000000010,
      ST_PREP  = 9'b000000100,
      ST_MUL   = 9'b000001000,
      ST_SUBV  = 9'b000010000,
      ST_DIVV  = 9'b000100000,
      ST_ROOTP = 9'b001000000,
      ST_ROOT  = 9'b010000000,
      ST_OUT   = 9'b100000000
   } back_state_type;

endpackage

FILE: hw/rtl/rmvs_queue.sv
module rmvs_queue #(
   parameter int WIDTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output rmvs_pkg::queue_status_type status
);
   import rmvs_pkg::*;

   logic [WIDTH-1:0]  mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   level_in = level_ff + QCNT_W'(1);
         2'b01:   level_in = level_ff - QCNT_W'(1);
         default: level_in = level_ff;
      endcase
      pop_data     = mem_ff[rd_ptr_ff];
      status.empty = (level_ff == '0);
      status.level = level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/rmvs_front.sv
module rmvs_front #(
   parameter int MAX_SAMPLES = 64,
   localparam int CW = $clog2(MAX_SAMPLES + 1),
   localparam int REC_W = 3 * CW + rmvs_pkg::SAMPLE_W + rmvs_pkg::SQUARE_W
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [rmvs_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_last,
   input  logic                                req_push,
   output logic                                req_full,
   input  rmvs_pkg::queue_status_type          q_status,
   output logic                                q_push,
   output logic [REC_W-1:0]                    q_data
);
   import rmvs_pkg::*;

   localparam int SW = SAMPLE_W + CW;
   localparam int QW = SQUARE_W + CW - 1;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_SAMPLES);

   logic                       accept;
   logic                       keep;
   logic [CW-1:0]              cnt_next;
   logic                       drop_next;
   logic signed [2*SAMPLE_W-1:0] square_full;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic                       drop_ff, drop_in;

   // sample stage: square and admission decision
   logic                       s1_valid_ff;
   logic                       s1_keep_ff;
   logic                       s1_last_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic [SQUARE_W-1:0]        s1_square_ff;
   logic [CW-1:0]              s1_count_ff;
   logic                       s1_drop_ff;

   // accumulate stage
   logic signed [SW-1:0]       sum_ff, sum_in, sum_add, sum_next;
   logic [QW-1:0]              sumsq_ff, sumsq_in, sumsq_add, sumsq_next;
   logic                       pend;
   logic [QCNT_W:0]            occupancy;

   always_comb begin
      accept      = req_push & ~req_full;
      keep        = (cnt_ff < MAX_C);
      cnt_next    = keep ? cnt_ff + CW'(1) : cnt_ff;
      drop_next   = drop_ff | ~keep;
      square_full = req_sample * req_sample;
      cnt_in      = cnt_ff;
      drop_in     = drop_ff;
      if (accept) begin
         if (req_last) begin
            cnt_in  = '0;
            drop_in = 1'b0;
         end else begin
            cnt_in  = cnt_next;
            drop_in = drop_next;
         end
      end
   end

   always_comb begin
      sum_add    = s1_keep_ff ? SW'(s1_sample_ff) : '0;
      sumsq_add  = s1_keep_ff ? QW'(s1_square_ff) : '0;
      sum_next   = sum_ff + sum_add;
      sumsq_next = sumsq_ff + sumsq_add;
      sum_in     = sum_ff;
      sumsq_in   = sumsq_ff;
      if (s1_valid_ff) begin
         sum_in   = s1_last_ff ? '0 : sum_next;
         sumsq_in = s1_last_ff ? '0 : sumsq_next;
      end
      q_push = s1_valid_ff & s1_last_ff;
      q_data = {sum_next, sumsq_next, s1_count_ff, s1_drop_ff};
      // reserve a queue slot for a run end still in the sample stage
      pend      = s1_valid_ff & s1_last_ff;
      occupancy = (QCNT_W + 1)'(q_status.level) + (QCNT_W + 1)'(pend);
      req_full  = (occupancy >= (QCNT_W + 1)'(QUEUE_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         drop_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
         sum_ff      <= '0;
         sumsq_ff    <= '0;
      end else begin
         cnt_ff      <= cnt_in;
         drop_ff     <= drop_in;
         s1_valid_ff <= accept;
         sum_ff      <= sum_in;
         sumsq_ff    <= sumsq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_keep_ff   <= keep;
         s1_last_ff   <= req_last;
         s1_sample_ff <= req_sample;
         s1_square_ff <= square_full[SQUARE_W-1:0];
         s1_count_ff  <= cnt_next;
         s1_drop_ff   <= drop_next;
      end
   end

endmodule

FILE: hw/rtl/rmvs_back.sv
module rmvs_back #(
   parameter int MAX_SAMPLES = 64,
   localparam int CW = $clog2(MAX_SAMPLES + 1),
   localparam int REC_W = 3 * CW + rmvs_pkg::SAMPLE_W + rmvs_pkg::SQUARE_W
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rmvs_pkg::queue_status_type          q_status,
   input  logic [REC_W-1:0]                    q_data,
   output logic                                q_pop,
   input  logic                                rsp_pop,
   output logic                                rsp_empty,
   output logic signed [rmvs_pkg::MEAN_W-1:0]  rsp_mean,
   output logic [rmvs_pkg::VAR_W-1:0]          rsp_variance,
   output logic [rmvs_pkg::SD_W-1:0]           rsp_std_dev,
   output logic [rmvs_pkg::COUNT_W-1:0]        rsp_sample_count,
   output logic                                rsp_overflowed
);
   import rmvs_pkg::*;

   localparam int SW     = SAMPLE_W + CW;
   localparam int QW     = SQUARE_W + CW - 1;
   localparam int MAGW   = SW - 1;
   localparam int NW     = 2 * MAGW;
   localparam int DW     = 2 * CW;
   localparam int STEP_W = $clog2(NW);
   localparam int SRW    = SD_W + 2;

   back_state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              last_step;

   // run record fields at the queue head
   logic signed [SW-1:0] rec_sum;
   logic [SW-1:0]        rec_abs;
   logic [QW-1:0]        rec_sumsq;
   logic [CW-1:0]        rec_cnt;
   logic                 rec_drop;

   logic              neg_ff;
   logic [MAGW-1:0]   mag_ff;
   logic [QW-1:0]     sumsq_ff;
   logic [CW-1:0]     n_ff;
   logic              drop_ff;
   logic [MEAN_W-1:0] mean_ff;
   logic [VAR_W-1:0]  var_ff;

   // shared restoring divider
   logic [NW-1:0] num_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] div_ff;
   logic [DW:0]   div_trial, div_diff;
   logic          div_ge;

   // shift-add multiplier for count times sum of squares
   logic [NW-1:0] acc_ff, mcand_ff, b_ff;
   logic [CW-1:0] mplier_ff;

   // digit-by-digit square root
   logic [2*SD_W-1:0] sv_ff;
   logic [SRW-1:0]    srem_ff;
   logic [SD_W-1:0]   root_ff;
   logic [SRW-1:0]    sq_trial, sq_sub;
   logic              sq_ge;

   logic                out_valid_ff, out_valid_in;
   logic                out_free;
   logic [CW+COUNT_W-1:0] n_wide;
   logic [MEAN_W-1:0]   out_mean_ff;
   logic [VAR_W-1:0]    out_var_ff;
   logic [SD_W-1:0]     out_sd_ff;
   logic [COUNT_W-1:0]  out_cnt_ff;
   logic                out_drop_ff;

   always_comb begin
      rec_sum   = q_data[REC_W-1 -: SW];
      rec_sumsq = q_data[CW+1 +: QW];
      rec_cnt   = q_data[1 +: CW];
      rec_drop  = q_data[0];
      rec_abs   = rec_sum[SW-1] ? -rec_sum : rec_sum;

      div_trial = {rem_ff, num_ff[NW-1]};
      div_ge    = (div_trial >= {1'b0, div_ff});
      div_diff  = div_trial - {1'b0, div_ff};

      sq_trial = {srem_ff[SD_W-1:0], sv_ff[2*SD_W-1 -: 2]};
      sq_sub   = {root_ff, 2'b01};
      sq_ge    = (sq_trial >= sq_sub);

      n_wide    = {{COUNT_W{1'b0}}, n_ff};
      last_step = (step_ff == '0);
      out_free  = ~out_valid_ff | rsp_pop;
      q_pop     = (state_ff == ST_IDLE) & ~q_status.empty;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = last_step ? step_ff : step_ff - STEP_W'(1);
      unique case (state_ff)
         ST_IDLE: begin
            step_in = STEP_W'(NW - 1);
            if (!q_status.empty) state_in = ST_DIVM;
         end
         ST_DIVM: begin
            if (last_step) state_in = ST_PREP;
         end
         ST_PREP: begin
            step_in  = STEP_W'(CW - 1);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (last_step) state_in = ST_SUBV;
         end
         ST_SUBV: begin
            step_in  = STEP_W'(NW - 1);
            state_in = ST_DIVV;
         end
         ST_DIVV: begin
            if (last_step) state_in = ST_ROOTP;
         end
         ST_ROOTP: begin
            step_in  = STEP_W'(SD_W - 1);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (last_step) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      out_valid_in = out_valid_ff;
      if (rsp_pop) out_valid_in = 1'b0;
      if ((state_ff == ST_OUT) && out_free) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      case (state_ff) inside
         ST_IDLE: begin
            neg_ff   <= rec_sum[SW-1];
            mag_ff   <= rec_abs[MAGW-1:0];
            sumsq_ff <= rec_sumsq;
            n_ff     <= rec_cnt;
            drop_ff  <= rec_drop;
            num_ff   <= NW'(rec_abs[MAGW-1:0]);
            rem_ff   <= '0;
            div_ff   <= DW'(rec_cnt);
         end
         ST_DIVM, ST_DIVV: begin
            num_ff <= {num_ff[NW-2:0], div_ge};
            rem_ff <= div_ge ? div_diff[DW-1:0] : div_trial[DW-1:0];
         end
         ST_PREP: begin
            mean_ff   <= neg_ff ? -num_ff[MEAN_W-1:0] : num_ff[MEAN_W-1:0];
            acc_ff    <= '0;
            mcand_ff  <= NW'(sumsq_ff);
            mplier_ff <= n_ff;
            b_ff      <= mag_ff * mag_ff;
            div_ff    <= n_ff * n_ff;
         end
         ST_MUL: begin
            if (mplier_ff[0]) acc_ff <= acc_ff + mcand_ff;
            mcand_ff  <= {mcand_ff[NW-2:0], 1'b0};
            mplier_ff <= mplier_ff >> 1;
         end
         ST_SUBV: begin
            // clamp at zero
            num_ff <= (acc_ff > b_ff) ? acc_ff - b_ff : '0;
            rem_ff <= '0;
         end
         ST_ROOTP: begin
            var_ff  <= num_ff[VAR_W-1:0];
            sv_ff   <= (2 * SD_W)'(num_ff[VAR_W-1:0]);
            srem_ff <= '0;
            root_ff <= '0;
         end
         ST_ROOT: begin
            srem_ff <= sq_ge ? sq_trial - sq_sub : sq_trial;
            root_ff <= {root_ff[SD_W-2:0], sq_ge};
            sv_ff   <= {sv_ff[2*SD_W-3:0], 2'b00};
         end
         default: begin
         end
      endcase
      if ((state_ff == ST_OUT) && out_free) begin
         out_mean_ff <= mean_ff;
         out_var_ff  <= var_ff;
         out_sd_ff   <= root_ff;
         out_cnt_ff  <= n_wide[COUNT_W-1:0];
         out_drop_ff <= drop_ff;
      end
   end

   assign rsp_empty        = ~out_valid_ff;
   assign rsp_mean         = out_mean_ff;
   assign rsp_variance     = out_var_ff;
   assign rsp_std_dev      = out_sd_ff;
   assign rsp_sample_count = out_cnt_ff;
   assign rsp_overflowed   = out_drop_ff;

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == ST_DIVM))
      else $error("queue pop did not start a run");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && !out_free |=> (state_ff == ST_OUT) && out_valid_ff)
      else $error("finished run left while result register busy");

   a_sd_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_sd_ff <= SD_W'(32768)))
      else $error("standard deviation above range");

endmodule

FILE: hw/rtl/run_mean_variance_stddev_unit.sv
// Channel   Ports                                         Direction
// req       req_push, req_full, req_sample, req_last      in  (queue write side)
// rsp       rsp_empty, rsp_pop, rsp_mean, rsp_variance,   out (queue read side)
//           rsp_std_dev, rsp_sample_count, rsp_overflowed
//
// One sample is taken every cycle while req_full is low; a two-stage front (square,
// accumulate) sums each run. A finished run waits in a two-entry queue; the back part
// takes one run at a time through the serial divider for the mean, the shift-add
// multiplier, the divider again for the variance and the 16-step square root.
// req_full rises while the queue and the run end in flight fill every slot.
// Synchronous reset clears the front accumulators, counters, queue and the result valid flag.
module run_mean_variance_stddev_unit #(
   parameter int MAX_SAMPLES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [rmvs_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_last,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [rmvs_pkg::MEAN_W-1:0]   rsp_mean,
   output logic [rmvs_pkg::VAR_W-1:0]           rsp_variance,
   output logic [rmvs_pkg::SD_W-1:0]            rsp_std_dev,
   output logic [rmvs_pkg::COUNT_W-1:0]         rsp_sample_count,
   output logic                                 rsp_overflowed
);
   import rmvs_pkg::*;

   localparam int CW    = $clog2(MAX_SAMPLES + 1);
   localparam int REC_W = 3 * CW + SAMPLE_W + SQUARE_W;

   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   logic [REC_W-1:0] q_wdata;
   logic [REC_W-1:0] q_rdata;

   rmvs_front #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_sample(req_sample),
      .req_last  (req_last),
      .req_push  (req_push),
      .req_full  (req_full),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   rmvs_queue #(
      .WIDTH(REC_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_wdata),
      .pop      (q_pop),
      .pop_data (q_rdata),
      .status   (q_status)
   );

   rmvs_back #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_data          (q_rdata),
      .q_pop           (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_mean        (rsp_mean),
      .rsp_variance    (rsp_variance),
      .rsp_std_dev     (rsp_std_dev),
      .rsp_sample_count(rsp_sample_count),
      .rsp_overflowed  (rsp_overflowed)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_status.level != QCNT_W'(QUEUE_DEPTH)))
      else $error("run record pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("run record popped from an empty queue");

   a_var_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_variance <= VAR_W'(1073741824)))
      else $error("variance above range");

endmodule
